FILE: src/cellular_cave_smoothing_step_macros.svh
// assertion helpers shared by the smoothing step
`ifndef CELLULAR_CAVE_SMOOTHING_STEP_MACROS_SVH
`define CELLULAR_CAVE_SMOOTHING_STEP_MACROS_SVH

// same-cycle implication, masked while reset is high
`define CCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, masked while reset is high
`define CCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: src/ccs_pkg.sv
package ccs_pkg;

   localparam int CFG_W = 9;
   localparam int THR_W = 4;
   localparam int IDX_W = 2;
   localparam int POS_W = 8;
   localparam int CNT_W = 4;
   localparam int WIN_W = 9;

   localparam int DEFAULT_MAX_COLS = 256;
   localparam int DEFAULT_MAX_ROWS = 256;

   localparam logic [CFG_W-1:0] RESET_ROWS      = 9'd64;
   localparam logic [CFG_W-1:0] RESET_COLS      = 9'd64;
   localparam logic [THR_W-1:0] RESET_THRESHOLD = 4'd5;

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] REG_GRID_ROWS      = 2'd0;
   localparam logic [IDX_W-1:0] REG_GRID_COLS      = 2'd1;
   localparam logic [IDX_W-1:0] REG_WALL_THRESHOLD = 2'd2;

   // window bit 3*r+c, r=0 top row, c=0 left column
   localparam logic [WIN_W-1:0] KEEP_LEFT_MASK = 9'h0DB;
   localparam logic [WIN_W-1:0] NEIGHBOR_MASK  = 9'h1EF;

   // line memory word: upper line bit and middle line bit of one column
   localparam int LINE_W      = 2;
   localparam int LINE_UPPER  = 1;
   localparam int LINE_MIDDLE = 0;

   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = 2;

   typedef struct packed {
      logic             edge_emit;
      logic             last;
      logic             main_emit;
      logic             clr;
      logic             top_en;
      logic             mid_en;
      logic             bot;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } ccs_op_type;

   typedef struct packed {
      logic             wall;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } ccs_res_type;

   function automatic logic [WIN_W-1:0] shift_in(logic [WIN_W-1:0] w, logic top,
                                                 logic mid, logic bot);
      logic [WIN_W-1:0] s;
      s    = (w >> 1) & KEEP_LEFT_MASK;
      s[2] = top;
      s[5] = mid;
      s[8] = bot;
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] count_walls(logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] n;
      logic [CNT_W-1:0] c;
      n = w & NEIGHBOR_MASK;
      c = '0;
      for (int i = 0; i < WIN_W; i++) begin
         c = c + CNT_W'(n[i]);
      end
      return c;
   endfunction

endpackage

FILE: src/ccs_ram.sv
module ccs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/ccs_front.sv
module ccs_front #(
   parameter int MAX_COLS = ccs_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = ccs_pkg::DEFAULT_MAX_ROWS,
   localparam int COL_W = $clog2(MAX_COLS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     cell_in,
   input  logic                     frame_start,
   input  logic [ccs_pkg::CFG_W-1:0] grid_rows,
   input  logic [ccs_pkg::CFG_W-1:0] grid_cols,
   output logic                     rd_en,
   output logic [COL_W-1:0]         rd_addr,
   output logic                     op_valid,
   output ccs_pkg::ccs_op_type      op,
   output logic [COL_W-1:0]         op_addr,
   output logic                     frame_idle
);

   import ccs_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS + 4);
   localparam int AW0   = (ROW_W > CFG_W) ? ROW_W : CFG_W;
   localparam int AW    = (AW0 > COL_W + 1) ? AW0 : COL_W + 1;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             done_ff, done_in;
   logic             op_valid_ff, op_valid_in;
   ccs_op_type       op_ff, op_in;
   logic [COL_W-1:0] op_addr_ff;

   logic [AW-1:0] rows, cols, gr, gc, r0, c0, r1, c1, c2;
   logic          done_eff, stop, edge_emit, last, main_emit, active;

   always_comb begin
      gr = AW'(grid_rows);
      gc = AW'(grid_cols);
      if (gr == '0) begin
         rows = AW'(1);
      end else if (gr > AW'(MAX_ROWS)) begin
         rows = AW'(MAX_ROWS);
      end else begin
         rows = gr;
      end
      if (gc == '0) begin
         cols = AW'(1);
      end else if (gc > AW'(MAX_COLS)) begin
         cols = AW'(MAX_COLS);
      end else begin
         cols = gc;
      end

      r0       = frame_start ? '0 : AW'(row_ff);
      c0       = frame_start ? '0 : AW'(col_ff);
      done_eff = frame_start ? 1'b0 : done_ff;

      // column beyond a shrunken width wraps first
      if (c0 >= cols) begin
         c1 = '0;
         r1 = r0 + AW'(1);
      end else begin
         c1 = c0;
         r1 = r0;
      end

      stop      = r1 > rows + AW'(1);
      edge_emit = (c1 == '0) && (r1 >= AW'(2));
      last      = edge_emit && (r1 == rows + AW'(1));
      main_emit = (c1 >= AW'(1)) && (r1 >= AW'(1)) && (r1 <= rows);
      c2        = c1 + AW'(1);
      active    = accept && !done_eff && !stop;

      op_in.edge_emit = edge_emit;
      op_in.last      = last;
      op_in.main_emit = main_emit;
      op_in.clr       = (c1 == '0);
      op_in.top_en    = r1 >= AW'(2);
      op_in.mid_en    = r1 >= AW'(1);
      op_in.bot       = (r1 < rows) && cell_in;
      op_in.row       = edge_emit ? POS_W'(r1 - AW'(2)) : POS_W'(r1 - AW'(1));
      op_in.col       = edge_emit ? POS_W'(cols - AW'(1)) : POS_W'(c1 - AW'(1));

      op_valid_in = active;
      row_in      = row_ff;
      col_in      = col_ff;
      done_in     = done_ff;
      if (accept) begin
         done_in = done_eff || stop || last;
      end
      if (active) begin
         if (last) begin
            row_in = ROW_W'(r1);
            col_in = COL_W'(c1);
         end else if (c2 >= cols) begin
            row_in = ROW_W'(r1 + AW'(1));
            col_in = '0;
         end else begin
            row_in = ROW_W'(r1);
            col_in = COL_W'(c2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         done_ff     <= 1'b1;
         op_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         done_ff     <= done_in;
         op_valid_ff <= op_valid_in;
      end
      op_ff      <= op_in;
      op_addr_ff <= COL_W'(c1);
   end

   assign rd_en      = active;
   assign rd_addr    = COL_W'(c1);
   assign op_valid   = op_valid_ff;
   assign op         = op_ff;
   assign op_addr    = op_addr_ff;
   assign frame_idle = done_ff;

endmodule

FILE: src/ccs_window.sv
module ccs_window #(
   parameter int MAX_COLS = ccs_pkg::DEFAULT_MAX_COLS,
   localparam int COL_W = $clog2(MAX_COLS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      op_valid,
   input  ccs_pkg::ccs_op_type       op,
   input  logic [COL_W-1:0]          op_addr,
   input  logic                      rd_en,
   input  logic [COL_W-1:0]          rd_addr,
   input  logic [ccs_pkg::LINE_W-1:0] ram_rdata,
   input  logic [ccs_pkg::THR_W-1:0] wall_threshold,
   output logic                      wr_en,
   output logic [COL_W-1:0]          wr_addr,
   output logic [ccs_pkg::LINE_W-1:0] wr_data,
   output logic                      push,
   output ccs_pkg::ccs_res_type      res
);

   import ccs_pkg::*;

   logic [WIN_W-1:0]  window_ff, window_in;
   logic              fwd_ff, fwd_in;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] rd;
   logic [WIN_W-1:0]  base, w_new, sel;
   logic              top, mid;

   always_comb begin
      // the column just written may be read again right away
      rd        = fwd_ff ? fwd_data_ff : ram_rdata;
      top       = op.top_en && rd[LINE_UPPER];
      mid       = op.mid_en && rd[LINE_MIDDLE];
      base      = op.clr ? '0 : window_ff;
      w_new     = shift_in(base, top, mid, op.bot);
      sel       = op.edge_emit ? shift_in(window_ff, 1'b0, 1'b0, 1'b0) : w_new;

      wr_en     = op_valid && !op.last;
      wr_addr   = op_addr;
      wr_data   = '0;
      wr_data[LINE_UPPER]  = rd[LINE_MIDDLE];
      wr_data[LINE_MIDDLE] = op.bot;

      window_in = wr_en ? w_new : window_ff;
      fwd_in    = rd_en && wr_en && (wr_addr == rd_addr);

      push      = op_valid && (op.edge_emit || op.main_emit);
      res.wall  = count_walls(sel) >= wall_threshold;
      res.row   = op.row;
      res.col   = op.col;
      res.last  = op.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fwd_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         fwd_ff    <= fwd_in;
      end
      fwd_data_ff <= wr_data;
   end

endmodule

FILE: src/ccs_outq.sv
module ccs_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ccs_pkg::ccs_res_type           push_data,
   input  logic                           out_stall,
   output logic                           out_valid,
   output ccs_pkg::ccs_res_type           out_data,
   output logic [ccs_pkg::OUTQ_PTR_W-1:0] count
);

   import ccs_pkg::*;

   ccs_res_type           slot_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] head_ff, head_in, tail_ff, tail_in, count_ff, count_in;
   logic                  pop;

   function automatic logic [OUTQ_PTR_W-1:0] bump(logic [OUTQ_PTR_W-1:0] p);
      return (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
   endfunction

   always_comb begin
      pop      = (count_ff != '0) && !out_stall;
      head_in  = pop ? bump(head_ff) : head_ff;
      tail_in  = push ? bump(tail_ff) : tail_ff;
      count_in = count_ff + OUTQ_PTR_W'(push) - OUTQ_PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[head_ff];
   assign count     = count_ff;

endmodule

FILE: src/cellular_cave_smoothing_step.sv
// result: the request one row and one column on yields a cell's result, via the result queue
// throughput: one request per cycle when req_stall is low, set by the single read-modify-write
//    of the line memory (read when taken, written back next, with a one-deep same-column bypass)
// reset: config returns to 64 x 64, threshold 5, no frame active; then a clearing pass
//    zeroes each line memory column, with requests stalled, csr writes still taken
module cellular_cave_smoothing_step #(
   parameter int MAX_COLS = ccs_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = ccs_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cell_in,
   input  logic                       req_frame_start,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_cell_out,
   output logic [ccs_pkg::POS_W-1:0]  rsp_out_row,
   output logic [ccs_pkg::POS_W-1:0]  rsp_out_col,
   output logic                       rsp_frame_last,
   // register writes
   input  logic                       csr_wr_en,
   input  logic [ccs_pkg::IDX_W-1:0]  csr_index,
   input  logic [ccs_pkg::CFG_W-1:0]  csr_wr_data
);

   import ccs_pkg::*;

`include "cellular_cave_smoothing_step_macros.svh"

   localparam int COL_W = $clog2(MAX_COLS);

   // configuration registers
   logic [CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0] grid_cols_ff, grid_cols_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   // clearing pass over the line memory
   logic             clr_ff, clr_in;
   logic [COL_W-1:0] clr_addr_ff, clr_addr_in;

   logic                accept;
   logic                rd_en;
   logic [COL_W-1:0]    rd_addr;
   logic                op_valid;
   ccs_op_type          op;
   logic [COL_W-1:0]    op_addr;
   logic                frame_idle;

   logic                win_wr_en;
   logic [COL_W-1:0]    win_wr_addr;
   logic [LINE_W-1:0]   win_wr_data;
   logic                push;
   ccs_res_type         push_res;

   logic                ram_wr_en;
   logic [COL_W-1:0]    ram_wr_addr;
   logic [LINE_W-1:0]   ram_wr_data;
   logic [LINE_W-1:0]   ram_rdata;

   ccs_res_type               q_data;
   logic [OUTQ_PTR_W-1:0]     q_count;
   logic [OUTQ_PTR_W:0]       in_flight;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      thr_in       = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_ROWS:      grid_rows_in = csr_wr_data;
            REG_GRID_COLS:      grid_cols_in = csr_wr_data;
            REG_WALL_THRESHOLD: thr_in       = THR_W'(csr_wr_data);
            default:            ;
         endcase
      end

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == COL_W'(MAX_COLS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= RESET_ROWS;
         grid_cols_ff <= RESET_COLS;
         thr_ff       <= RESET_THRESHOLD;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         thr_ff       <= thr_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   // each request in the window stage may still need one queue slot
   assign in_flight = (OUTQ_PTR_W + 1)'(op_valid) + (OUTQ_PTR_W + 1)'(q_count);
   assign req_stall = clr_ff || (in_flight > (OUTQ_PTR_W + 1)'(OUTQ_DEPTH - 1));
   assign accept    = req_valid && !req_stall;

   ccs_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cell_in     (req_cell_in),
      .frame_start (req_frame_start),
      .grid_rows   (grid_rows_ff),
      .grid_cols   (grid_cols_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .op_valid    (op_valid),
      .op          (op),
      .op_addr     (op_addr),
      .frame_idle  (frame_idle)
   );

   // line memory: upper and middle line bit per column
   assign ram_wr_en   = clr_ff || win_wr_en;
   assign ram_wr_addr = clr_ff ? clr_addr_ff : win_wr_addr;
   assign ram_wr_data = clr_ff ? '0 : win_wr_data;

   ccs_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLS)
   ) u_lines (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   ccs_window #(
      .MAX_COLS (MAX_COLS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op             (op),
      .op_addr        (op_addr),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .ram_rdata      (ram_rdata),
      .wall_threshold (thr_ff),
      .wr_en          (win_wr_en),
      .wr_addr        (win_wr_addr),
      .wr_data        (win_wr_data),
      .push           (push),
      .res            (push_res)
   );

   // result queue decouples the window stage from the result channel
   ccs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_cell_out   = q_data.wall;
   assign rsp_out_row    = q_data.row;
   assign rsp_out_col    = q_data.col;
   assign rsp_frame_last = q_data.last;

   // queue never takes a result while full unless one leaves
   `CCS_ASSERT_NOW(a_queue_room, clock, reset,
      push, (q_count < OUTQ_PTR_W'(OUTQ_DEPTH)) || (rsp_valid && !rsp_stall))
   // the closing result of a frame only appears once the frame is marked done
   `CCS_ASSERT_NOW(a_last_done, clock, reset, push && push_res.last, frame_idle)
   // nothing enters the window stage while the memory is being cleared
   `CCS_ASSERT_NEXT(a_clear_quiet, clock, reset, clr_ff, !op_valid)

endmodule
